### rtl/triangle_fragment_shader_unit_assert.svh
// Assertion macros shared by the shader checker
`ifndef TRIANGLE_FRAGMENT_SHADER_UNIT_ASSERT_SVH
`define TRIANGLE_FRAGMENT_SHADER_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during reset
`define TFS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shader check failed");
// Next-cycle implication, sampled on clk, off during reset
`define TFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shader check failed");
`endif

### rtl/tfs_pkg.sv
// Shared types and constants of the triangle fragment shader
package tfs_pkg;
	localparam int CoordW = 12;
	localparam int DiffW  = 13;
	localparam int ProdW  = 26;
	localparam int AreaW  = 26;
	localparam int SumW   = 28;
	localparam int NumW   = 36;
	localparam int CoefW  = 21;
	localparam int AffW   = 36;
	localparam int AddrW  = 16;
	localparam int RgbW   = 24;
	localparam int CfgW   = 63;
	localparam int IdxW   = 3;

	localparam logic [1:0] MODE_VERTEX  = 2'd0;
	localparam logic [1:0] MODE_FLAT    = 2'd1;
	localparam logic [1:0] MODE_TEXTURE = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	localparam logic FUNC_SHADE = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [IdxW-1:0] REG_MODE   = 3'd0;
	localparam logic [IdxW-1:0] REG_FLAT   = 3'd1;
	localparam logic [IdxW-1:0] REG_VTX0   = 3'd2;
	localparam logic [IdxW-1:0] REG_VTX1   = 3'd3;
	localparam logic [IdxW-1:0] REG_VTX2   = 3'd4;
	localparam logic [IdxW-1:0] REG_WEIGHT = 3'd5;
	localparam logic [IdxW-1:0] REG_MAPU   = 3'd6;
	localparam logic [IdxW-1:0] REG_MAPV   = 3'd7;

	// Per-beat side data that travels down the pipe
	typedef struct packed {
		logic            wr;
		logic [1:0]      mode;
		logic [RgbW-1:0] prev;
		logic [AddrW-1:0] waddr;
		logic [RgbW-1:0] wdata;
		logic            found;
		logic [RgbW-1:0] texel;
		logic            zero;
	} side_t;
endpackage

### rtl/triangle_fragment_shader_unit.sv
// A shaded pixel passes through the stage registers, the divider and the output register.
// Throughput: one beat per cycle; the pipe advances as a whole while the
// output register is empty or taken, and texel writes use a slot but no output.
// The eight-stage divider for the vertex weights sets the depth.
// Reset clears the valid bits and registers (mode flat); the texel store holds garbage.
module triangle_fragment_shader_unit #(
	parameter int TEX_WIDTH  = 256,
	parameter int TEX_HEIGHT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tfs_pkg::IdxW-1:0]     cfg_index,
	input  logic [tfs_pkg::CfgW-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [11:0]                  pixel_x,
	input  logic [11:0]                  pixel_y,
	input  logic [7:0]                   prev_r,
	input  logic [7:0]                   prev_g,
	input  logic [7:0]                   prev_b,
	input  logic [15:0]                  texel_addr,
	input  logic [23:0]                  texel_rgb,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_r,
	output logic [7:0]                   out_g,
	output logic [7:0]                   out_b,
	output logic                         texel_found
);
	localparam int DivN = 8;

	logic        en;
	logic [1:0]  mode_q;
	logic [23:0] flat_q;
	logic [47:0] vtx_q [3];
	logic [8:0]  weight_q;
	logic [62:0] mapu_q;
	logic [62:0] mapv_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tfs_pkg::MODE_FLAT;
			flat_q   <= '0;
			vtx_q[0] <= '0;
			vtx_q[1] <= '0;
			vtx_q[2] <= '0;
			weight_q <= '0;
			mapu_q   <= '0;
			mapv_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfs_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				tfs_pkg::REG_FLAT:   flat_q   <= cfg_data[23:0];
				tfs_pkg::REG_VTX0:   vtx_q[0] <= cfg_data[47:0];
				tfs_pkg::REG_VTX1:   vtx_q[1] <= cfg_data[47:0];
				tfs_pkg::REG_VTX2:   vtx_q[2] <= cfg_data[47:0];
				tfs_pkg::REG_WEIGHT: weight_q <= cfg_data[8:0];
				tfs_pkg::REG_MAPU:   mapu_q   <= cfg_data;
				tfs_pkg::REG_MAPV:   mapv_q   <= cfg_data;
				default:             mode_q   <= mode_q;
			endcase
		end
	end

	// Advance whole pipe unless the output beat is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// Stage 1: edge vectors and products
	logic signed [12:0] dx [3];
	logic signed [12:0] dy [3];
	logic signed [12:0] xs, ys;
	logic signed [25:0] pa_d [3];
	logic signed [25:0] pb_d [3];
	logic signed [33:0] pux_d, puy_d, pvx_d, pvy_d;
	tfs_pkg::side_t     side_d1;

	always_comb begin
		xs = $signed({1'b0, pixel_x});
		ys = $signed({1'b0, pixel_y});
		for (int k = 0; k < 3; k++) begin
			dx[k] = $signed({1'b0, vtx_q[k][11:0]}) - xs;
			dy[k] = $signed({1'b0, vtx_q[k][23:12]}) - ys;
		end
		pa_d[0] = dx[1] * dy[2];
		pb_d[0] = dy[1] * dx[2];
		pa_d[1] = dx[2] * dy[0];
		pb_d[1] = dy[2] * dx[0];
		pa_d[2] = dx[0] * dy[1];
		pb_d[2] = dy[0] * dx[1];
		pux_d = $signed(mapu_q[20:0]) * xs;
		puy_d = $signed(mapu_q[41:21]) * ys;
		pvx_d = $signed(mapv_q[20:0]) * xs;
		pvy_d = $signed(mapv_q[41:21]) * ys;
		side_d1       = '0;
		side_d1.wr    = (func == tfs_pkg::FUNC_WRITE);
		side_d1.mode  = mode_q;
		side_d1.prev  = {prev_r, prev_g, prev_b};
		side_d1.waddr = texel_addr;
		side_d1.wdata = texel_rgb;
		side_d1.found = 1'b1;
	end

	logic               vld_s1;
	tfs_pkg::side_t     side_s1;
	logic signed [25:0] pa_s1 [3];
	logic signed [25:0] pb_s1 [3];
	logic signed [33:0] pux_s1, puy_s1, pvx_s1, pvy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d1;
			pa_s1   <= pa_d;
			pb_s1   <= pb_d;
			pux_s1  <= pux_d;
			puy_s1  <= puy_d;
			pvx_s1  <= pvx_d;
			pvy_s1  <= pvy_d;
		end
	end

	// Stage 2: areas and affine sums
	logic signed [26:0] cr_d [3];
	logic [25:0]        area_d [3];
	logic signed [35:0] su_d, sv_d;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cr_d[k]   = 27'(pa_s1[k]) - 27'(pb_s1[k]);
			area_d[k] = cr_d[k][26] ? 26'(-cr_d[k]) : 26'(cr_d[k]);
		end
		su_d = 36'(pux_s1) + 36'(puy_s1) + 36'($signed(mapu_q[62:42]));
		sv_d = 36'(pvx_s1) + 36'(pvy_s1) + 36'($signed(mapv_q[62:42]));
	end

	logic               vld_s2;
	tfs_pkg::side_t     side_s2;
	logic [25:0]        area_s2 [3];
	logic signed [35:0] su_s2, sv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			area_s2 <= area_d;
			su_s2   <= su_d;
			sv_s2   <= sv_d;
		end
	end

	// Truncate texture coordinates toward zero and form the store index
	logic signed [35:0] tu, tv;
	logic               inrange;
	logic [15:0]        raddr;
	tfs_pkg::side_t     side_d3;

	always_comb begin
		tu = su_s2[35] ? ((su_s2 + 36'sd1023) >>> 10) : (su_s2 >>> 10);
		tv = sv_s2[35] ? ((sv_s2 + 36'sd1023) >>> 10) : (sv_s2 >>> 10);
		inrange = !tu[35] && !tv[35] && (tu < 36'(TEX_WIDTH)) && (tv < 36'(TEX_HEIGHT));
		raddr   = 16'(tu[15:0] + tv[15:0] * 16'(TEX_WIDTH));
		side_d3 = side_s2;
		if (side_s2.mode == tfs_pkg::MODE_TEXTURE) begin
			side_d3.found = inrange;
		end
	end

	logic [23:0] texel_rd;

	tfs_texmem u_texmem (
		.clk   (clk),
		.wr_en (en && vld_s2 && side_s2.wr),
		.rd_en (en && vld_s2 && !side_s2.wr),
		.waddr (side_s2.waddr),
		.wdata (side_s2.wdata),
		.raddr (raddr),
		.rdata (texel_rd)
	);

	logic           vld_s3;
	tfs_pkg::side_t side_s3;
	logic [25:0]    area_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_d3;
			area_s3 <= area_s2;
		end
	end

	// Stage 3: area sum and weighted color products
	logic [27:0]    sum_d4;
	logic [33:0]    prod_d4 [3][3];
	tfs_pkg::side_t side_d4;

	always_comb begin
		sum_d4 = 28'(area_s3[0]) + 28'(area_s3[1]) + 28'(area_s3[2]);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				prod_d4[i][k] = area_s3[k] * vtx_q[k][47 - 8*i -: 8];
			end
		end
		side_d4       = side_s3;
		side_d4.texel = texel_rd;
	end

	logic           vld_s4;
	tfs_pkg::side_t side_s4;
	logic [27:0]    sum_s4;
	logic [33:0]    prod_s4 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_d4;
			sum_s4  <= sum_d4;
			prod_s4 <= prod_d4;
		end
	end

	// Stage 4: numerators and zero-sum flag
	logic [2:0][35:0] num_d5;
	tfs_pkg::side_t   side_d5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_d5[i] = 36'(prod_s4[i][0]) + 36'(prod_s4[i][1]) + 36'(prod_s4[i][2]);
		end
		side_d5      = side_s4;
		side_d5.zero = (sum_s4 == '0);
	end

	logic             dvld [DivN+1];
	tfs_pkg::side_t   dside [DivN+1];
	logic [27:0]      dsum [DivN+1];
	logic [2:0][35:0] drem [DivN+1];
	logic [2:0][7:0]  dq [DivN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld[0] <= 1'b0;
		end else if (en) begin
			dvld[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside[0] <= side_d5;
			dsum[0]  <= sum_s4;
			drem[0]  <= num_d5;
			dq[0]    <= '0;
		end
	end

	// Stages 5..12: one quotient bit each, MSB first
	for (genvar g = 0; g < DivN; g++) begin : g_div
		tfs_div_stage #(
			.QBIT (DivN - 1 - g)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dvld[g]),
			.side_i (dside[g]),
			.sum_i  (dsum[g]),
			.rem_i  (drem[g]),
			.q_i    (dq[g]),
			.vld_o  (dvld[g+1]),
			.side_o (dside[g+1]),
			.sum_o  (dsum[g+1]),
			.rem_o  (drem[g+1]),
			.q_o    (dq[g+1])
		);
	end

	// Final stage: pick material color and blend with the frame
	tfs_pkg::side_t fs;
	logic [23:0]    col;
	logic [8:0]     w;
	logic [8:0]     wn;
	logic [16:0]    mix [3];
	logic [7:0]     res [3];

	always_comb begin
		fs = dside[DivN];
		// Quotient lane 0 is red, so it goes to the top byte
		unique case (fs.mode)
			tfs_pkg::MODE_VERTEX:  col = fs.zero ? vtx_q[0][47:24] :
				{dq[DivN][0], dq[DivN][1], dq[DivN][2]};
			tfs_pkg::MODE_FLAT:    col = flat_q;
			tfs_pkg::MODE_TEXTURE: col = fs.found ? fs.texel : fs.prev;
			tfs_pkg::MODE_NONE:    col = fs.prev;
			default:               col = fs.prev;
		endcase
		w  = (weight_q > 9'd256) ? 9'd256 : weight_q;
		wn = 9'd256 - w;
		for (int i = 0; i < 3; i++) begin
			mix[i] = 17'(fs.prev[23 - 8*i -: 8]) * 17'(w) +
				17'(col[23 - 8*i -: 8]) * 17'(wn);
			res[i] = mix[i][15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvld[DivN] && !fs.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_r       <= res[0];
			out_g       <= res[1];
			out_b       <= res[2];
			texel_found <= fs.found;
		end
	end
endmodule

### rtl/tfs_texmem.sv
// Texel store: one write or one registered read per cycle
module tfs_texmem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [tfs_pkg::AddrW-1:0]  waddr,
	input  logic [tfs_pkg::RgbW-1:0]   wdata,
	input  logic [tfs_pkg::AddrW-1:0]  raddr,
	output logic [tfs_pkg::RgbW-1:0]   rdata
);
	logic [tfs_pkg::RgbW-1:0] mem [2**tfs_pkg::AddrW];

	// Write texel or read one, in pipeline order
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/tfs_div_stage.sv
// One restoring-division stage: resolves one quotient bit per channel
module tfs_div_stage #(
	parameter int QBIT = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  tfs_pkg::side_t                      side_i,
	input  logic [tfs_pkg::SumW-1:0]            sum_i,
	input  logic [2:0][tfs_pkg::NumW-1:0]       rem_i,
	input  logic [2:0][7:0]                     q_i,
	output logic                                vld_o,
	output tfs_pkg::side_t                      side_o,
	output logic [tfs_pkg::SumW-1:0]            sum_o,
	output logic [2:0][tfs_pkg::NumW-1:0]       rem_o,
	output logic [2:0][7:0]                     q_o
);
	logic [tfs_pkg::NumW-1:0]       trial;
	logic [2:0][tfs_pkg::NumW-1:0]  rem_d;
	logic [2:0][7:0]                q_d;

	// Subtract the shifted divisor where it fits
	always_comb begin
		trial = tfs_pkg::NumW'(sum_i) << QBIT;
		for (int i = 0; i < 3; i++) begin
			rem_d[i] = rem_i[i];
			q_d[i]   = q_i[i];
			if (rem_i[i] >= trial) begin
				rem_d[i]     = rem_i[i] - trial;
				q_d[i][QBIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			sum_o  <= sum_i;
			rem_o  <= rem_d;
			q_o    <= q_d;
		end
	end
endmodule

### rtl/tfs_checker.sv
// Port-level checker for the shader, bound to the top level
`include "triangle_fragment_shader_unit_assert.svh"
module tfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_r,
	input logic [7:0] out_g,
	input logic [7:0] out_b,
	input logic       texel_found
);
	`TFS_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
	`TFS_ASSERT_NOW(a_stall_from_output, in_stall, out_valid && out_stall)
	`TFS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
	`TFS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({out_r, out_g, out_b, texel_found}))
endmodule

bind triangle_fragment_shader_unit tfs_checker u_tfs_checker (.*);

### verif/triangle_fragment_shader_unit_checker.sv
// Shader checker: tracks registers and texels, predicts pixel colors, compares results
module triangle_fragment_shader_unit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tfs_pkg::IdxW-1:0]     cfg_index,
	input  logic [tfs_pkg::CfgW-1:0]     cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         func,
	input  logic [11:0]                  pixel_x,
	input  logic [11:0]                  pixel_y,
	input  logic [7:0]                   prev_r,
	input  logic [7:0]                   prev_g,
	input  logic [7:0]                   prev_b,
	input  logic [15:0]                  texel_addr,
	input  logic [23:0]                  texel_rgb,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [7:0]                   out_r,
	input  logic [7:0]                   out_g,
	input  logic [7:0]                   out_b,
	input  logic                         texel_found,
	output int                           mismatches,
	output int                           pending
);
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       found;
	} pixel_t;

	logic [1:0]  mode_q;
	logic [23:0] flat_q;
	logic [47:0] vtx_q [3];
	logic [8:0]  weight_q;
	logic [62:0] map_u_q;
	logic [62:0] map_v_q;
	logic [23:0] texels [0:65535];
	pixel_t      colors_due [$];

	// Doubled area of the triangle (pixel, va, vb), absolute
	function automatic longint twice_area(longint px, longint py, logic [47:0] va,
			logic [47:0] vb);
		longint ax, ay, bx, by, c;
		ax = va[11:0];
		ay = va[23:12];
		bx = vb[11:0];
		by = vb[23:12];
		ax = ax - px;
		ay = ay - py;
		bx = bx - px;
		by = by - py;
		c = ax * by - ay * bx;
		return (c < 0) ? -c : c;
	endfunction

	// Apply one Q10.10 map, truncating toward zero
	function automatic longint map_coord(logic [62:0] m, longint x, longint y);
		logic signed [20:0] cx, cy, c0;
		longint s;
		cx = m[20:0];
		cy = m[41:21];
		c0 = m[62:42];
		s = longint'(cx) * x + longint'(cy) * y + longint'(c0);
		return s / 1024;
	endfunction

	function automatic pixel_t shade_pixel(logic [11:0] x, logic [11:0] y,
			logic [23:0] prev);
		pixel_t      res;
		logic [23:0] col;
		longint      px, py, a [3], sum, num, u, v, w;
		int          ch, k, sh;
		px = x;
		py = y;
		col = prev;
		res.found = 1'b1;
		case (mode_q)
			tfs_pkg::MODE_VERTEX: begin
				a[0] = twice_area(px, py, vtx_q[1], vtx_q[2]);
				a[1] = twice_area(px, py, vtx_q[2], vtx_q[0]);
				a[2] = twice_area(px, py, vtx_q[0], vtx_q[1]);
				sum = a[0] + a[1] + a[2];
				for (ch = 0; ch < 3; ch++) begin
					sh = 24 + 8 * (2 - ch);
					if (sum == 0) begin
						col[8*(2-ch) +: 8] = vtx_q[0][sh +: 8];
					end else begin
						num = 0;
						for (k = 0; k < 3; k++)
							num += a[k] * longint'(vtx_q[k][sh +: 8]);
						col[8*(2-ch) +: 8] = 8'(num / sum);
					end
				end
			end
			tfs_pkg::MODE_FLAT: col = flat_q;
			tfs_pkg::MODE_TEXTURE: begin
				u = map_coord(map_u_q, px, py);
				v = map_coord(map_v_q, px, py);
				if (u >= 0 && u < 256 && v >= 0 && v < 256)
					col = texels[16'(u + v * 256)];
				else
					res.found = 1'b0;
			end
			default: col = prev;
		endcase
		w = (weight_q > 256) ? 256 : weight_q;
		res.r = 8'((longint'(prev[23:16]) * w + longint'(col[23:16]) * (256 - w)) >> 8);
		res.g = 8'((longint'(prev[15:8]) * w + longint'(col[15:8]) * (256 - w)) >> 8);
		res.b = 8'((longint'(prev[7:0]) * w + longint'(col[7:0]) * (256 - w)) >> 8);
		return res;
	endfunction

	// Track registers, texels and expected colors; compare each output beat
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			mode_q <= tfs_pkg::MODE_FLAT;
			flat_q <= '0;
			vtx_q[0] <= '0;
			vtx_q[1] <= '0;
			vtx_q[2] <= '0;
			weight_q <= '0;
			map_u_q <= '0;
			map_v_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tfs_pkg::REG_MODE:   mode_q <= cfg_data[1:0];
					tfs_pkg::REG_FLAT:   flat_q <= cfg_data[23:0];
					tfs_pkg::REG_VTX0:   vtx_q[0] <= cfg_data[47:0];
					tfs_pkg::REG_VTX1:   vtx_q[1] <= cfg_data[47:0];
					tfs_pkg::REG_VTX2:   vtx_q[2] <= cfg_data[47:0];
					tfs_pkg::REG_WEIGHT: weight_q <= cfg_data[8:0];
					tfs_pkg::REG_MAPU:   map_u_q <= cfg_data;
					tfs_pkg::REG_MAPV:   map_v_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (func == tfs_pkg::FUNC_WRITE)
					texels[texel_addr] = texel_rgb;
				else
					colors_due.push_back(shade_pixel(pixel_x, pixel_y,
						{prev_r, prev_g, prev_b}));
			end
			if (out_valid && !out_stall) begin
				got = {out_r, out_g, out_b, texel_found};
				if (colors_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat r=%h g=%h b=%h found=%b",
						$time, out_r, out_g, out_b, texel_found);
				end else begin
					want = colors_due.pop_front();
					if (got !== want) begin
						mismatches++;
						$display({"%0t: result mismatch expected r=%h g=%h b=%h found=%b,",
							" actual r=%h g=%h b=%h found=%b"},
							$time, want.r, want.g, want.b, want.found,
							got.r, got.g, got.b, got.found);
					end
				end
			end
			pending = colors_due.size();
		end
	end
endmodule

### verif/triangle_fragment_shader_unit_tb.sv
// Shader testbench top: clock, reset, stimulus and verdict
module triangle_fragment_shader_unit_tb;
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [tfs_pkg::IdxW-1:0]  cfg_index = '0;
	logic [tfs_pkg::CfgW-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      func = tfs_pkg::FUNC_SHADE;
	logic [11:0]               pixel_x = '0;
	logic [11:0]               pixel_y = '0;
	logic [7:0]                prev_r = '0;
	logic [7:0]                prev_g = '0;
	logic [7:0]                prev_b = '0;
	logic [15:0]               texel_addr = '0;
	logic [23:0]               texel_rgb = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [7:0]                out_r;
	logic [7:0]                out_g;
	logic [7:0]                out_b;
	logic                      texel_found;
	int                        mismatches;
	int                        pending;
	bit                        quiet = 1'b0;
	bit                        hold_req = 1'b0;
	bit                        tex_written [65536];
	logic [1:0]                mode_cur = tfs_pkg::MODE_FLAT;
	logic [62:0]               map_u_cur = '0;
	logic [62:0]               map_v_cur = '0;

	triangle_fragment_shader_unit dut (.*);
	triangle_fragment_shader_unit_checker checker_i (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("triangle_fragment_shader_unit regression: fail");
		$finish;
	end

	// Drive receiver stall: random bursts, one long hold on request, none when quiet
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Apply one Q10.10 map, truncating toward zero
	function automatic longint map_coord(logic [62:0] m, longint x, longint y);
		logic signed [20:0] cx, cy, c0;
		cx = m[20:0];
		cy = m[41:21];
		c0 = m[62:42];
		return (longint'(cx) * x + longint'(cy) * y + longint'(c0)) / 1024;
	endfunction

	// Offer one beat and hold it until accepted
	task automatic send_beat(logic f, logic [11:0] x, logic [11:0] y, logic [23:0] prev,
			logic [15:0] addr, logic [23:0] rgb);
		logic s;
		if (f == tfs_pkg::FUNC_WRITE)
			tex_written[addr] = 1'b1;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pixel_x <= x;
		pixel_y <= y;
		{prev_r, prev_g, prev_b} <= prev;
		texel_addr <= addr;
		texel_rgb <= rgb;
		do begin
			@(negedge clk);
			s = in_stall;
			@(posedge clk);
		end while (s);
	endtask

	// Shade one pixel; write its texel first if a lookup would hit an unwritten one
	task automatic shade(logic [11:0] x, logic [11:0] y, logic [23:0] prev);
		longint      u, v;
		logic [15:0] addr;
		u = map_coord(map_u_cur, longint'(x), longint'(y));
		v = map_coord(map_v_cur, longint'(x), longint'(y));
		addr = 16'(u + v * 256);
		if (mode_cur == tfs_pkg::MODE_TEXTURE && u >= 0 && u < 256 && v >= 0 && v < 256
				&& !tex_written[addr])
			send_beat(tfs_pkg::FUNC_WRITE, 12'($urandom), 12'($urandom), 24'($urandom),
				addr, 24'($urandom));
		send_beat(tfs_pkg::FUNC_SHADE, x, y, prev, 16'($urandom), 24'($urandom));
	endtask

	// Drain, let the pipe settle, then write one register
	task automatic write_reg(logic [tfs_pkg::IdxW-1:0] idx, logic [tfs_pkg::CfgW-1:0] data);
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			tfs_pkg::REG_MODE: mode_cur = data[1:0];
			tfs_pkg::REG_MAPU: map_u_cur = data;
			tfs_pkg::REG_MAPV: map_v_cur = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [62:0] pack_map(int cx, int cy, int c0);
		return {21'(c0), 21'(cy), 21'(cx)};
	endfunction

	function automatic logic [tfs_pkg::CfgW-1:0] rand_vertex();
		return tfs_pkg::CfgW'({24'($urandom), 12'($urandom), 12'($urandom)});
	endfunction

	// Mostly maps that land in the texture, sometimes raw bits
	function automatic logic [62:0] rand_map();
		if ($urandom_range(0, 3) == 0)
			return {31'($urandom), 32'($urandom)};
		return pack_map($urandom_range(0, 120) - 30, $urandom_range(0, 120) - 30,
			$urandom_range(0, 1024 * 300) - 1024 * 30);
	endfunction

	initial begin
		int n, ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: flat black, no blend
		shade(12'd0, 12'd0, 24'hFFFFFF);
		shade(12'hFFF, 12'hFFF, 24'h000000);

		// Flat extremes with full and saturated weights
		write_reg(tfs_pkg::REG_FLAT, tfs_pkg::CfgW'(24'hFFFFFF));
		shade(12'd5, 12'd7, 24'h000000);
		write_reg(tfs_pkg::REG_WEIGHT, tfs_pkg::CfgW'(9'd256));
		shade(12'd5, 12'd7, 24'h123456);
		write_reg(tfs_pkg::REG_WEIGHT, tfs_pkg::CfgW'(9'h1FF));
		shade(12'd5, 12'd7, 24'hABCDEF);
		write_reg(tfs_pkg::REG_WEIGHT, tfs_pkg::CfgW'(9'd128));
		shade(12'd5, 12'd7, 24'h00FF80);

		// Vertex mode: a real triangle, then all vertices equal (zero area sum)
		write_reg(tfs_pkg::REG_MODE, tfs_pkg::CfgW'(tfs_pkg::MODE_VERTEX));
		write_reg(tfs_pkg::REG_WEIGHT, tfs_pkg::CfgW'(9'd0));
		write_reg(tfs_pkg::REG_VTX0, tfs_pkg::CfgW'({24'hFF0000, 12'd0, 12'd0}));
		write_reg(tfs_pkg::REG_VTX1, tfs_pkg::CfgW'({24'h00FF00, 12'd0, 12'hFFF}));
		write_reg(tfs_pkg::REG_VTX2, tfs_pkg::CfgW'({24'h0000FF, 12'hFFF, 12'd0}));
		shade(12'd100, 12'd200, 24'h0);
		shade(12'hFFF, 12'hFFF, 24'hFFFFFF);
		shade(12'd0, 12'd0, 24'h0);
		write_reg(tfs_pkg::REG_VTX0, tfs_pkg::CfgW'(48'hFFFF_FFFF_FFFF));
		write_reg(tfs_pkg::REG_VTX1, tfs_pkg::CfgW'(48'hFFFF_FFFF_FFFF));
		write_reg(tfs_pkg::REG_VTX2, tfs_pkg::CfgW'(48'hFFFF_FFFF_FFFF));
		shade(12'd3, 12'd9, 24'h0);
		shade(12'hFFF, 12'hFFF, 24'h0);

		// Texture mode: identity-like map, then out of range both ways
		write_reg(tfs_pkg::REG_MODE, tfs_pkg::CfgW'(tfs_pkg::MODE_TEXTURE));
		write_reg(tfs_pkg::REG_MAPU, tfs_pkg::CfgW'(pack_map(1024, 0, 0)));
		write_reg(tfs_pkg::REG_MAPV, tfs_pkg::CfgW'(pack_map(0, 1024, 0)));
		shade(12'd0, 12'd0, 24'h0);
		shade(12'd255, 12'd255, 24'h0);
		shade(12'd256, 12'd3, 24'h55AA55);
		write_reg(tfs_pkg::REG_MAPU, tfs_pkg::CfgW'(pack_map(0, 0, -1)));
		shade(12'd1, 12'd1, 24'h010203);
		write_reg(tfs_pkg::REG_MAPU, {tfs_pkg::CfgW{1'b1}});
		write_reg(tfs_pkg::REG_MAPV, {tfs_pkg::CfgW{1'b1}});
		shade(12'hFFF, 12'd0, 24'h0);

		// No material: previous color passes through
		write_reg(tfs_pkg::REG_MODE, tfs_pkg::CfgW'(tfs_pkg::MODE_NONE));
		shade(12'd9, 12'd9, 24'hC0FFEE);

		// Random phases; the final one without idling
		for (ph = 0; ph < 14; ph++) begin
			quiet = (ph == 13);
			write_reg(tfs_pkg::REG_MODE, tfs_pkg::CfgW'(($urandom_range(0, 9) < 8) ?
				$urandom_range(0, 2) : tfs_pkg::MODE_NONE));
			write_reg(tfs_pkg::REG_FLAT, tfs_pkg::CfgW'(24'($urandom)));
			write_reg(tfs_pkg::REG_VTX0, rand_vertex());
			write_reg(tfs_pkg::REG_VTX1, rand_vertex());
			write_reg(tfs_pkg::REG_VTX2, rand_vertex());
			write_reg(tfs_pkg::REG_WEIGHT, tfs_pkg::CfgW'(($urandom_range(0, 4) == 0) ?
				9'($urandom) : 9'($urandom_range(0, 256))));
			write_reg(tfs_pkg::REG_MAPU, tfs_pkg::CfgW'(rand_map()));
			write_reg(tfs_pkg::REG_MAPV, tfs_pkg::CfgW'(rand_map()));
			for (n = 0; n < 85; n++) begin
				if (ph == 6 && n == 10)
					hold_req = 1'b1;
				if ($urandom_range(0, 9) == 0)
					send_beat(tfs_pkg::FUNC_WRITE, 12'($urandom), 12'($urandom),
						24'($urandom), 16'($urandom), 24'($urandom));
				else
					shade(12'($urandom), 12'($urandom), 24'($urandom));
			end
		end

		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("triangle_fragment_shader_unit regression: pass");
		else
			$display("triangle_fragment_shader_unit regression: fail");
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl
rtl/tfs_pkg.sv
rtl/tfs_texmem.sv
rtl/tfs_div_stage.sv
rtl/triangle_fragment_shader_unit.sv
rtl/tfs_checker.sv
verif/triangle_fragment_shader_unit_checker.sv
verif/triangle_fragment_shader_unit_tb.sv
